// ===== sv/mfr_pkg.sv =====
// Shared constants, types and tables for the field-relative mecanum mixer.
package mfr_pkg;

    // Pipeline depth choices
    localparam int CORDIC_STAGES   = 16;
    localparam int MAX_SCALE_STEPS = 64;

    // Configuration register widths
    localparam int HTS_W = 12;
    localparam int RPM_W = 32;
    localparam int LIM_W = 15;
    localparam int CFG_W = 32;

    // Angle and rotator widths
    localparam int ANG_W = 15;
    localparam int XW    = 34;
    localparam int ZW    = 33;

    // Gain correction 1/K in Q30, split into two 15-bit halves
    localparam logic [29:0] GAIN_Q30   = 30'd652032874;
    localparam int          GAIN_SPLIT = 15;
    localparam logic [14:0] GAIN_HI    = GAIN_Q30[29:15];
    localparam logic [14:0] GAIN_LO    = GAIN_Q30[14:0];
    localparam int          PROD_W     = XW + 16;
    localparam int          FULL_W     = 66;
    localparam int          XR_W       = FULL_W - 30;
    localparam int          XK_W       = 47;

    // Wheel mix and rpm conversion widths
    localparam int MIX_W  = 30;
    localparam int AMIX_W = MIX_W - 1;
    localparam int PP_W   = AMIX_W + 16;
    localparam int M_W    = 62;
    localparam logic [M_W-1:0] ROUND_Q = M_W'(500000);

    // Division by 10^6 = 2^6 * 15625, by multiplying with a 57-bit reciprocal
    localparam int DIV_W  = M_W - 6;
    localparam int NL_W   = 28;
    localparam int RL_W   = 29;
    localparam int RCP_W  = 57;
    localparam int RCP_SH = 70;
    // ceil(2^70 / 15625), exact for every dividend below 2^56
    localparam logic [RCP_W-1:0] RECIP = 57'd75557863725914324;

    // Wheel magnitude widths
    localparam int MAG_W = 41;
    localparam int B_W   = MAG_W + 1;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_HALF_TRACK = 2'd0,
        CFG_RPM_SCALE  = 2'd1,
        CFG_RPM_LIMIT  = 2'd2
    } mfr_cfg_idx_t;

    // Rotated velocity handed from the rotator to the rpm stages
    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [15:0]   om;
    } mfr_rot_t;

    // One wheel speed in sign and magnitude form, Q16 rpm
    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } mfr_whl_t;

    // Arctangent of 2^-i, 2^32 per turn
    function automatic logic signed [ZW-1:0] mfr_atan(input int idx);
        case (idx)
            0:  mfr_atan = ZW'(536870912);
            1:  mfr_atan = ZW'(316933406);
            2:  mfr_atan = ZW'(167458907);
            3:  mfr_atan = ZW'(85011924);
            4:  mfr_atan = ZW'(42667331);
            5:  mfr_atan = ZW'(21354465);
            6:  mfr_atan = ZW'(10680862);
            7:  mfr_atan = ZW'(5340245);
            8:  mfr_atan = ZW'(2670163);
            9:  mfr_atan = ZW'(1335087);
            10: mfr_atan = ZW'(667544);
            11: mfr_atan = ZW'(333772);
            12: mfr_atan = ZW'(166886);
            13: mfr_atan = ZW'(83443);
            14: mfr_atan = ZW'(41721);
            15: mfr_atan = ZW'(20860);
            16: mfr_atan = ZW'(10430);
            17: mfr_atan = ZW'(5215);
            18: mfr_atan = ZW'(2607);
            19: mfr_atan = ZW'(1303);
            20: mfr_atan = ZW'(651);
            21: mfr_atan = ZW'(325);
            22: mfr_atan = ZW'(162);
            23: mfr_atan = ZW'(81);
            default: mfr_atan = '0;
        endcase
    endfunction

endpackage

// ===== sv/mfr_if.sv =====
// Handshake interfaces for the command and wheel item channels.
interface mfr_cmd_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] cmd_vx_mm;
    logic signed [15:0] cmd_vy_mm;
    logic signed [15:0] cmd_omega_mrad;
    logic [12:0]        yaw_encoder;

    modport source (output valid, cmd_vx_mm, cmd_vy_mm, cmd_omega_mrad, yaw_encoder,
                    input ready);
    modport sink   (input valid, cmd_vx_mm, cmd_vy_mm, cmd_omega_mrad, yaw_encoder,
                    output ready);
endinterface

interface mfr_wheel_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] wheel_one_rpm;
    logic signed [15:0] wheel_two_rpm;
    logic signed [15:0] wheel_three_rpm;
    logic signed [15:0] wheel_four_rpm;
    logic               was_scaled;
    logic               not_settled;

    modport source (output valid, wheel_one_rpm, wheel_two_rpm, wheel_three_rpm,
                    wheel_four_rpm, was_scaled, not_settled, input ready);
    modport sink   (input valid, wheel_one_rpm, wheel_two_rpm, wheel_three_rpm,
                    wheel_four_rpm, was_scaled, not_settled, output ready);
endinterface

// ===== sv/mfr_cordic.sv =====
// Angle preparation and pipelined CORDIC rotator, one stage per iteration.
module mfr_cordic import mfr_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_vld,
    input  logic signed [15:0] vx,
    input  logic signed [15:0] vy,
    input  logic signed [15:0] om,
    input  logic [12:0]        enc,
    output logic               out_vld,
    output mfr_rot_t           rot
);

    localparam logic signed [ANG_W-1:0] QTR  = ANG_W'(2048);
    localparam logic signed [ANG_W-1:0] HALF = ANG_W'(4096);
    localparam logic signed [ANG_W-1:0] TURN = ANG_W'(8192);

    logic signed [ANG_W-1:0] ang;
    logic signed [ANG_W-1:0] ang_w;
    logic signed [ANG_W-1:0] pa;
    logic signed [ANG_W-1:0] pf;
    logic                    flip;
    logic signed [XW-1:0]    x0;
    logic signed [XW-1:0]    y0;
    logic signed [ZW-1:0]    z0;

    logic signed [XW-1:0] x_reg  [CORDIC_STAGES+1];
    logic signed [XW-1:0] y_reg  [CORDIC_STAGES+1];
    logic signed [ZW-1:0] z_reg  [CORDIC_STAGES+1];
    logic signed [15:0]   om_reg [CORDIC_STAGES+1];
    logic                 vld_reg [CORDIC_STAGES+1];

    // Signed encoder angle, minus a quarter turn, wrapped, negated, folded to +-90 degrees
    always_comb
    begin
        ang   = ANG_W'($signed(enc));
        ang_w = ang - QTR;
        if (ang_w <= -HALF)
        begin
            ang_w = ang_w + TURN;
        end
        pa   = -ang_w;
        flip = 1'b0;
        pf   = pa;
        if (pa > QTR)
        begin
            flip = 1'b1;
            pf   = pa - HALF;
        end
        else if (pa < -QTR)
        begin
            flip = 1'b1;
            pf   = pa + HALF;
        end
        x0 = XW'(vx) <<< 14;
        y0 = XW'(vy) <<< 14;
        if (flip)
        begin
            x0 = -x0;
            y0 = -y0;
        end
        z0 = ZW'(pf) <<< 19;
    end

    // Capture the prepared vector
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]  <= x0;
            y_reg[0]  <= y0;
            z_reg[0]  <= z0;
            om_reg[0] <= om;
        end
    end

    // One micro-rotation per stage
    for (genvar s = 0; s < CORDIC_STAGES; s++)
    begin : g_stage
        logic signed [XW-1:0] xs;
        logic signed [XW-1:0] ys;
        logic signed [XW-1:0] x_next;
        logic signed [XW-1:0] y_next;
        logic signed [ZW-1:0] z_next;

        always_comb
        begin
            xs = y_reg[s] >>> s;
            ys = x_reg[s] >>> s;
            if (!z_reg[s][ZW-1])
            begin
                x_next = x_reg[s] - xs;
                y_next = y_reg[s] + ys;
                z_next = z_reg[s] - mfr_atan(s);
            end
            else
            begin
                x_next = x_reg[s] + xs;
                y_next = y_reg[s] - ys;
                z_next = z_reg[s] + mfr_atan(s);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[s+1] <= vld_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[s+1]  <= x_next;
                y_reg[s+1]  <= y_next;
                z_reg[s+1]  <= z_next;
                om_reg[s+1] <= om_reg[s];
            end
        end
    end

    assign out_vld = vld_reg[CORDIC_STAGES];
    assign rot.x   = x_reg[CORDIC_STAGES];
    assign rot.y   = y_reg[CORDIC_STAGES];
    assign rot.om  = om_reg[CORDIC_STAGES];

endmodule

// ===== sv/mfr_rpm.sv =====
// Gain correction, wheel mix, rpm scaling and pipelined division by 10^6.
module mfr_rpm import mfr_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_vld,
    input  mfr_rot_t         rot,
    input  logic [HTS_W-1:0] hts,
    input  logic [RPM_W-1:0] rpm,
    output logic             out_vld,
    output mfr_whl_t [3:0]   whl
);

    localparam int NST   = 9;
    localparam int NH_W  = DIV_W - NL_W;
    localparam int RH_W  = RCP_W - RL_W;
    localparam int HH_W  = NH_W + RH_W;
    localparam int HL_W  = NH_W + RL_W;
    localparam int LH_W  = NL_W + RH_W;
    localparam int LL_W  = NL_W + RL_W;
    localparam int S1_W  = HL_W + 1;
    localparam int SUM_W = HH_W + RL_W + 1;
    localparam int Q_SH  = RCP_SH - NL_W;

    logic vld_reg [NST];

    // Gain partial products
    logic signed [PROD_W-1:0] xh_reg, xl_reg, yh_reg, yl_reg;
    logic signed [15:0]       om_reg;
    // Gain-corrected values times 1000, yaw term
    logic signed [FULL_W-1:0] fx, fy;
    logic signed [XR_W-1:0]   xr, yr;
    logic signed [XK_W-1:0]   xk_reg, yk_reg;
    logic signed [MIX_W-1:0]  w_reg;
    // Velocities in um/s
    logic signed [MIX_W-1:0]  xu_reg, yu_reg, wu_reg;
    // Mixed wheel speeds
    logic signed [MIX_W-1:0]  mix_reg [4];
    // rpm partial products
    logic                     pn_reg [4];
    logic [PP_W-1:0]          pl_reg [4];
    logic [PP_W-1:0]          ph_reg [4];
    // Rounded dividend
    logic                     dn_reg [4];
    logic [DIV_W-1:0]         dd_reg [4];
    // Reciprocal products, partial sums and quotient
    logic                     n1_reg [4];
    logic                     n2_reg [4];
    logic                     n3_reg [4];
    logic [HH_W-1:0]          hh_reg [4];
    logic [HL_W-1:0]          hl_reg [4];
    logic [LH_W-1:0]          lh_reg [4];
    logic [LL_W-1:0]          ll_reg [4];
    logic [HH_W-1:0]          hc_reg [4];
    logic [S1_W-1:0]          s1_reg [4];
    logic [RL_W-1:0]          lt_reg [4];
    logic [MAG_W-1:0]         qm_reg [4];

    // Valid bits of the arithmetic stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NST; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= in_vld;
            for (int i = 1; i < NST; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // Round the gain product to Q0, then scale to micrometers
    always_comb
    begin
        fx = (FULL_W'(xh_reg) <<< GAIN_SPLIT) + FULL_W'(xl_reg) + (FULL_W'(1) <<< 29);
        fy = (FULL_W'(yh_reg) <<< GAIN_SPLIT) + FULL_W'(yl_reg) + (FULL_W'(1) <<< 29);
        xr = XR_W'(fx >>> 30);
        yr = XR_W'(fy >>> 30);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // Multiply by the two halves of the gain correction
            xh_reg <= rot.x * $signed({1'b0, GAIN_HI});
            xl_reg <= rot.x * $signed({1'b0, GAIN_LO});
            yh_reg <= rot.y * $signed({1'b0, GAIN_HI});
            yl_reg <= rot.y * $signed({1'b0, GAIN_LO});
            om_reg <= rot.om;

            xk_reg <= xr * $signed(11'sd1000);
            yk_reg <= yr * $signed(11'sd1000);
            w_reg  <= om_reg * $signed({1'b0, hts});

            xu_reg <= MIX_W'((xk_reg + (XK_W'(1) <<< 13)) >>> 14);
            yu_reg <= MIX_W'((yk_reg + (XK_W'(1) <<< 13)) >>> 14);
            wu_reg <= w_reg;

            // Mecanum mix
            mix_reg[0] <= -(xu_reg - yu_reg + wu_reg);
            mix_reg[1] <= xu_reg + yu_reg - wu_reg;
            mix_reg[2] <= xu_reg - yu_reg - wu_reg;
            mix_reg[3] <= -(xu_reg + yu_reg + wu_reg);
        end
    end

    // Magnitude times rpm factor in two halves, then add half of 10^6
    for (genvar k = 0; k < 4; k++)
    begin : g_whl
        logic [AMIX_W-1:0] am;

        assign am = mix_reg[k][MIX_W-1] ? AMIX_W'(-mix_reg[k]) : AMIX_W'(mix_reg[k]);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pn_reg[k] <= mix_reg[k][MIX_W-1];
                pl_reg[k] <= PP_W'(am) * PP_W'(rpm[15:0]);
                ph_reg[k] <= PP_W'(am) * PP_W'(rpm[31:16]);
                dn_reg[k] <= pn_reg[k];
                dd_reg[k] <= DIV_W'((M_W'({ph_reg[k], 16'h0}) + M_W'(pl_reg[k]) + ROUND_Q)
                                    >> 6);
            end
        end
    end

    // Divide by 15625: four partial products with the reciprocal, add, take the top bits
    for (genvar k = 0; k < 4; k++)
    begin : g_div
        logic [SUM_W-1:0] sm;

        assign sm = (SUM_W'(hc_reg[k]) << RL_W) + SUM_W'(s1_reg[k]) + SUM_W'(lt_reg[k]);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n1_reg[k] <= dn_reg[k];
                hh_reg[k] <= HH_W'(dd_reg[k][DIV_W-1:NL_W]) * HH_W'(RECIP[RCP_W-1:RL_W]);
                hl_reg[k] <= HL_W'(dd_reg[k][DIV_W-1:NL_W]) * HL_W'(RECIP[RL_W-1:0]);
                lh_reg[k] <= LH_W'(dd_reg[k][NL_W-1:0]) * LH_W'(RECIP[RCP_W-1:RL_W]);
                ll_reg[k] <= LL_W'(dd_reg[k][NL_W-1:0]) * LL_W'(RECIP[RL_W-1:0]);

                n2_reg[k] <= n1_reg[k];
                s1_reg[k] <= S1_W'(hl_reg[k]) + (S1_W'(lh_reg[k]) << 1);
                hc_reg[k] <= hh_reg[k];
                lt_reg[k] <= ll_reg[k][LL_W-1:NL_W];

                n3_reg[k] <= n2_reg[k];
                qm_reg[k] <= sm[Q_SH+MAG_W-1:Q_SH];
            end
        end
    end

    assign out_vld = vld_reg[NST-1];
    for (genvar k = 0; k < 4; k++)
    begin : g_out
        assign whl[k].neg = n3_reg[k];
        assign whl[k].mag = qm_reg[k];
    end

endmodule

// ===== sv/mfr_limit.sv =====
// Bounded 0.9 speed limiting over pipelined steps, rounding and saturation.
module mfr_limit import mfr_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_vld,
    input  mfr_whl_t [3:0]     whl,
    input  logic [LIM_W-1:0]   lim,
    output logic               out_vld,
    output logic signed [15:0] rpm_one,
    output logic signed [15:0] rpm_two,
    output logic signed [15:0] rpm_three,
    output logic signed [15:0] rpm_four,
    output logic               scaled,
    output logic               unsettled
);

    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] a;
        logic [B_W-1:0]   b;
        logic [B_W-1:0]   q3;
    } mfr_mid_t;

    // True if any positive wheel is above the ceiling
    function automatic logic over_lim(input mfr_whl_t [3:0] w, input logic [LIM_W-1:0] l);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k < 4; k++)
        begin
            if (!w[k].neg && (w[k].mag > MAG_W'({l, 16'h0})))
            begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    mfr_whl_t [3:0] sw  [MAX_SCALE_STEPS+1];
    logic           ssc [MAX_SCALE_STEPS+1];
    logic           svl [MAX_SCALE_STEPS+1];

    assign sw[0]  = whl;
    assign ssc[0] = 1'b0;
    assign svl[0] = in_vld;

    for (genvar s = 0; s < MAX_SCALE_STEPS; s++)
    begin : g_step
        mfr_mid_t [3:0] mid_reg;
        logic           go_reg;
        logic           msc_reg;
        logic           mvl_reg;
        mfr_whl_t [3:0] out_reg;
        logic           osc_reg;
        logic           ovl_reg;
        logic           go;

        assign go = over_lim(sw[s], lim);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                mvl_reg <= 1'b0;
                ovl_reg <= 1'b0;
            end
            else if (en)
            begin
                mvl_reg <= svl[s];
                ovl_reg <= mvl_reg;
            end
        end

        // First half: ceiling check and start of the divide by ten of a+9
        for (genvar k = 0; k < 4; k++)
        begin : g_a
            logic [B_W-1:0] b;
            logic [B_W-1:0] q1;
            logic [B_W-1:0] q2;

            always_comb
            begin
                b  = B_W'(sw[s][k].mag) + B_W'(9);
                q1 = (b >> 1) + (b >> 2);
                q2 = q1 + (q1 >> 4);
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    mid_reg[k].neg <= sw[s][k].neg;
                    mid_reg[k].a   <= sw[s][k].mag;
                    mid_reg[k].b   <= b;
                    mid_reg[k].q3  <= q2 + (q2 >> 8);
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                go_reg  <= go;
                msc_reg <= ssc[s] | go;
                osc_reg <= msc_reg;
            end
        end

        // Second half: finish the quotient, correct by one, subtract
        for (genvar k = 0; k < 4; k++)
        begin : g_b
            logic [B_W-1:0] q4;
            logic [B_W-1:0] q5;
            logic [B_W-1:0] qq;
            logic [B_W-1:0] r;
            logic [B_W-1:0] qc;

            always_comb
            begin
                q4 = mid_reg[k].q3 + (mid_reg[k].q3 >> 16);
                q5 = q4 + (q4 >> 32);
                qq = q5 >> 3;
                r  = mid_reg[k].b - ((qq << 3) + (qq << 1));
                qc = (r > B_W'(9)) ? qq + B_W'(1) : qq;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    out_reg[k].neg <= mid_reg[k].neg;
                    out_reg[k].mag <= go_reg ? mid_reg[k].a - qc[MAG_W-1:0] : mid_reg[k].a;
                end
            end
        end

        assign sw[s+1]  = out_reg;
        assign ssc[s+1] = osc_reg;
        assign svl[s+1] = ovl_reg;
    end

    // Round Q16 to rpm and saturate
    logic signed [15:0] sat [4];

    for (genvar k = 0; k < 4; k++)
    begin : g_sat
        logic signed [B_W-1:0] sq;
        logic signed [B_W-1:0] rq;

        always_comb
        begin
            sq = $signed(B_W'(sw[MAX_SCALE_STEPS][k].mag));
            if (sw[MAX_SCALE_STEPS][k].neg)
            begin
                sq = -sq;
            end
            rq = (sq + (B_W'(1) <<< 15)) >>> 16;
            if (rq > B_W'(32767))
            begin
                sat[k] = 16'sh7fff;
            end
            else if (rq < -B_W'(32768))
            begin
                sat[k] = 16'sh8000;
            end
            else
            begin
                sat[k] = rq[15:0];
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld <= 1'b0;
        end
        else if (en)
        begin
            out_vld <= svl[MAX_SCALE_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rpm_one   <= sat[0];
            rpm_two   <= sat[1];
            rpm_three <= sat[2];
            rpm_four  <= sat[3];
            scaled    <= ssc[MAX_SCALE_STEPS];
            unsettled <= over_lim(sw[MAX_SCALE_STEPS], lim);
        end
    end

endmodule

// ===== sv/mecanum_field_relative_mix_unit.sv =====
// Top level of the field-relative mecanum wheel mixer.
//
//  channel | direction | contents
//  --------+-----------+--------------------------------------------------
//  cmd     | in        | vx, vy (mm/s), omega (mrad/s), 13-bit yaw encoder
//  wheel   | out       | four saturated motor rpm, was_scaled, not_settled
//  cfg_*   | in        | write-only registers: half track, rpm factor, limit
//
//  One item enters per cycle while the output is not stalled; the pipeline runs
//  through the CORDIC, the rpm stages, the limiting steps and an output register.
//  The 0.9 limiting takes two stages per step and sets most of the depth.
//  Reset clears the valid bits and loads the register defaults.
//  A stalled output freezes the whole pipeline; nothing is dropped or repeated.
module mecanum_field_relative_mix_unit import mfr_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    mfr_cmd_if.sink           cmd,
    mfr_wheel_if.source       wheel,
    input  logic              cfg_wr_en,
    input  logic [1:0]        cfg_index,
    input  logic [CFG_W-1:0]  cfg_data
);

    logic [HTS_W-1:0] hts_reg;
    logic [RPM_W-1:0] rpm_reg;
    logic [LIM_W-1:0] lim_reg;

    logic             en;
    logic             rot_vld;
    mfr_rot_t         rot;
    logic             whl_vld;
    mfr_whl_t [3:0]   whl;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hts_reg <= HTS_W'(400);
            rpm_reg <= '0;
            lim_reg <= LIM_W'(9000);
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_HALF_TRACK: hts_reg <= cfg_data[HTS_W-1:0];
                CFG_RPM_SCALE:  rpm_reg <= cfg_data[RPM_W-1:0];
                CFG_RPM_LIMIT:  lim_reg <= cfg_data[LIM_W-1:0];
                default:        ;
            endcase
        end
    end

    // Advance the pipeline unless a result is waiting
    assign en        = !wheel.valid || wheel.ready;
    assign cmd.ready = en;

    mfr_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (cmd.valid),
        .vx      (cmd.cmd_vx_mm),
        .vy      (cmd.cmd_vy_mm),
        .om      (cmd.cmd_omega_mrad),
        .enc     (cmd.yaw_encoder),
        .out_vld (rot_vld),
        .rot     (rot)
    );

    mfr_rpm u_rpm (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (rot_vld),
        .rot     (rot),
        .hts     (hts_reg),
        .rpm     (rpm_reg),
        .out_vld (whl_vld),
        .whl     (whl)
    );

    mfr_limit u_limit (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_vld    (whl_vld),
        .whl       (whl),
        .lim       (lim_reg),
        .out_vld   (wheel.valid),
        .rpm_one   (wheel.wheel_one_rpm),
        .rpm_two   (wheel.wheel_two_rpm),
        .rpm_three (wheel.wheel_three_rpm),
        .rpm_four  (wheel.wheel_four_rpm),
        .scaled    (wheel.was_scaled),
        .unsettled (wheel.not_settled)
    );

endmodule

// ===== sv/mfr_checker.sv =====
// Port-level checks for the mixer, bound to the top level.
module mfr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] w1,
    input logic [15:0] w2,
    input logic [15:0] w3,
    input logic [15:0] w4,
    input logic        scaled,
    input logic        unsettled
);

    // A waiting result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("wheel item withdrawn while stalled");

    // Input is held off only by a stalled result
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("command channel stalled without output back-pressure");

    // Unsettled needs at least one scaling step
    a_unsettled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && unsettled |-> scaled)
        else $error("not_settled without scaling");

    // Unsettled means a wheel is still on the positive side
    a_positive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && unsettled |-> !(w1[15] && w2[15] && w3[15] && w4[15]))
        else $error("not_settled with all wheels negative");

endmodule

bind mecanum_field_relative_mix_unit mfr_checker u_mfr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (cmd.ready),
    .out_valid (wheel.valid),
    .out_ready (wheel.ready),
    .w1        (wheel.wheel_one_rpm),
    .w2        (wheel.wheel_two_rpm),
    .w3        (wheel.wheel_three_rpm),
    .w4        (wheel.wheel_four_rpm),
    .scaled    (wheel.was_scaled),
    .unsettled (wheel.not_settled)
);

// ===== verif/mfr_tb_if.sv =====
// Note: the channel interfaces come from the RTL tree (sv/mfr_if.sv); this file holds shared test types.
package mfr_tb_pkg;
    typedef struct {
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic signed [15:0] om;
        logic [12:0]        enc;
    } cmd_item_t;

    typedef struct {
        logic signed [15:0] w1;
        logic signed [15:0] w2;
        logic signed [15:0] w3;
        logic signed [15:0] w4;
        logic               scaled;
        logic               unsettled;
    } wheel_item_t;
endpackage

// ===== verif/tb.sv =====
// Self-checking testbench for the field-relative mecanum wheel mixer.
module tb;
    import mfr_pkg::*;
    import mfr_tb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY    = 155;
    localparam int IDLE_LIMIT = 20000;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    mfr_cmd_if   cmd();
    mfr_wheel_if wheel();

    mecanum_field_relative_mix_unit i_dut (
        .clk(clk), .rst_n(rst_n), .cmd(cmd.sink), .wheel(wheel.source),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Predictor copy of the registers
    logic [11:0] half_track;
    logic [31:0] rpm_scale;
    logic [14:0] rpm_limit;

    cmd_item_t   pending_cmds[$];
    wheel_item_t expected_wheels[$];
    int errors;
    int n_sent;
    int n_checked;
    int n_scaled;
    int n_unsettled;
    int idle_cycles;
    bit hold_sender;
    int burst_left;
    int gap_left;
    int stall_phase;

    // Atan of 2^-i, 2^32 per turn
    function automatic longint atan_step(input int i);
        longint tab[24] = '{536870912, 316933406, 167458907, 85011924, 42667331,
            21354465, 10680862, 5340245, 2670163, 1335087, 667544, 333772,
            166886, 83443, 41721, 20860, 10430, 5215, 2607, 1303, 651, 325,
            162, 81};
        return tab[i];
    endfunction

    function automatic longint rnd_shift(input longint v, input int n);
        return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function automatic longint div_half_away(input longint p, input longint d);
        if (p >= 0)
            return (p + d / 2) / d;
        return -((-p + d / 2) / d);
    endfunction

    function automatic logic signed [15:0] clamp16(input longint v);
        if (v > 32767)
            return 16'sh7fff;
        if (v < -32768)
            return 16'sh8000;
        return 16'(v);
    endfunction

    // Compute the wheel item a command produces
    function automatic wheel_item_t mix_wheels(input cmd_item_t c);
        longint ang;
        longint rot;
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        longint xu;
        longint yu;
        longint w;
        longint lim;
        longint q[4];
        int steps;
        bit above;
        wheel_item_t r;
        ang = (c.enc >= 4096) ? longint'(c.enc) - 8192 : longint'(c.enc);
        ang -= 2048;
        if (ang <= -4096)
            ang += 8192;
        rot = -ang;
        x = longint'(c.vx) * 16384;
        y = longint'(c.vy) * 16384;
        if (rot > 2048)
        begin
            x = -x; y = -y; rot -= 4096;
        end
        else if (rot < -2048)
        begin
            x = -x; y = -y; rot += 4096;
        end
        z = rot * 524288;
        for (int i = 0; i < CORDIC_STAGES; i++)
        begin
            xs = y >>> i;
            ys = x >>> i;
            if (z >= 0)
            begin
                x -= xs; y += ys; z -= atan_step(i);
            end
            else
            begin
                x += xs; y -= ys; z += atan_step(i);
            end
        end
        xu = rnd_shift(rnd_shift(x * 652032874, 30) * 1000, 14);
        yu = rnd_shift(rnd_shift(y * 652032874, 30) * 1000, 14);
        w = longint'(c.om) * longint'(half_track);
        q[0] = -(xu - yu + w);
        q[1] = xu + yu - w;
        q[2] = xu - yu - w;
        q[3] = -(xu + yu + w);
        for (int k = 0; k < 4; k++)
            q[k] = div_half_away(q[k] * longint'(rpm_scale), 1000000);
        lim = longint'(rpm_limit) * 65536;
        steps = 0;
        forever
        begin
            above = 0;
            for (int k = 0; k < 4; k++)
                if (q[k] > lim)
                    above = 1;
            if (!above || steps >= MAX_SCALE_STEPS)
                break;
            for (int k = 0; k < 4; k++)
                q[k] = (q[k] * 9) / 10;
            steps++;
        end
        r.w1 = clamp16(rnd_shift(q[0], 16));
        r.w2 = clamp16(rnd_shift(q[1], 16));
        r.w3 = clamp16(rnd_shift(q[2], 16));
        r.w4 = clamp16(rnd_shift(q[3], 16));
        r.scaled = (steps > 0);
        r.unsettled = above;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch on %s: got %0d, expected %0d", what, got, want);
        errors++;
    endtask

    always
    begin
        clk = 1'b0; #6;
        clk = 1'b1; #6;
    end

    // Driver: bursts and gaps, fed from the pending queue
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd.valid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            if (cmd.valid && cmd.ready)
            begin
                expected_wheels.push_back(mix_wheels(pending_cmds.pop_front()));
                n_sent++;
                if (burst_left > 0)
                    burst_left--;
            end
            if (burst_left == 0 && gap_left == 0)
            begin
                burst_left = $urandom_range(1, 40);
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
            else if (burst_left == 0)
                gap_left--;
            // Hold an offered item until it is taken
            if ((cmd.valid && !cmd.ready) ||
                (pending_cmds.size() > 0 && !hold_sender && burst_left > 0))
            begin
                cmd.valid <= 1'b1;
                cmd.cmd_vx_mm <= pending_cmds[0].vx;
                cmd.cmd_vy_mm <= pending_cmds[0].vy;
                cmd.cmd_omega_mrad <= pending_cmds[0].om;
                cmd.yaw_encoder <= pending_cmds[0].enc;
            end
            else
                cmd.valid <= 1'b0;
        end
    end

    // Monitor: receiver stall pattern and checking
    always @(posedge clk or negedge rst_n)
    begin
        wheel_item_t want;
        if (!rst_n)
        begin
            wheel.ready <= 1'b0;
            stall_phase = 0;
            idle_cycles = 0;
        end
        else
        begin
            if (wheel.valid && wheel.ready)
            begin
                if (expected_wheels.size() == 0)
                begin
                    report_mismatch("unexpected wheel item count", 1, 0);
                end
                else
                begin
                    want = expected_wheels.pop_front();
                    n_checked++;
                    if (want.scaled) n_scaled++;
                    if (want.unsettled) n_unsettled++;
                    if (wheel.wheel_one_rpm !== want.w1)
                        report_mismatch("wheel_one_rpm", wheel.wheel_one_rpm, want.w1);
                    if (wheel.wheel_two_rpm !== want.w2)
                        report_mismatch("wheel_two_rpm", wheel.wheel_two_rpm, want.w2);
                    if (wheel.wheel_three_rpm !== want.w3)
                        report_mismatch("wheel_three_rpm", wheel.wheel_three_rpm, want.w3);
                    if (wheel.wheel_four_rpm !== want.w4)
                        report_mismatch("wheel_four_rpm", wheel.wheel_four_rpm, want.w4);
                    if (wheel.was_scaled !== want.scaled)
                        report_mismatch("was_scaled", wheel.was_scaled, want.scaled);
                    if (wheel.not_settled !== want.unsettled)
                        report_mismatch("not_settled", wheel.not_settled, want.unsettled);
                end
            end
            // Watchdog on cycles without any accepted item
            if ((wheel.valid && wheel.ready) || (cmd.valid && cmd.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout with %0d items outstanding", expected_wheels.size());
                $display("FAIL");
                $finish;
            end
            stall_phase = (stall_phase + 1) % 64;
            if (stall_phase < 20)
                wheel.ready <= 1'b1;
            else if (stall_phase < 40)
                wheel.ready <= ($urandom_range(0, 2) != 0);
            else
                wheel.ready <= ($urandom_range(0, 4) == 0);
        end
    end

    task automatic add_cmd(input logic [15:0] vx, input logic [15:0] vy,
                           input logic [15:0] om, input logic [12:0] enc);
        cmd_item_t c;
        c.vx = vx; c.vy = vy; c.om = om; c.enc = enc;
        pending_cmds.push_back(c);
    endtask

    task automatic add_random(input int count);
        logic [15:0] v[3];
        for (int n = 0; n < count; n++)
        begin
            for (int j = 0; j < 3; j++)
                case ($urandom_range(0, 3))
                    0: v[j] = $urandom();
                    1: v[j] = 16'($signed($urandom_range(0, 6000)) - 3000);
                    2: v[j] = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
                    default: v[j] = 16'($signed($urandom_range(0, 600)) - 300);
                endcase
            add_cmd(v[0], v[1], v[2], 13'($urandom()));
        end
    endtask

    task automatic drain();
        while (pending_cmds.size() != 0 || expected_wheels.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_reg(input mfr_cfg_idx_t idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_HALF_TRACK: half_track = val[11:0];
            CFG_RPM_SCALE:  rpm_scale = val;
            CFG_RPM_LIMIT:  rpm_limit = val[14:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [11:0] h, input logic [31:0] s, input logic [14:0] l);
        write_reg(CFG_HALF_TRACK, h);
        write_reg(CFG_RPM_SCALE, s);
        write_reg(CFG_RPM_LIMIT, l);
    endtask

    initial
    begin
        errors = 0; n_sent = 0; n_checked = 0; n_scaled = 0; n_unsettled = 0;
        hold_sender = 0;
        half_track = 400; rpm_scale = 0; rpm_limit = 9000;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0; cfg_index = CFG_HALF_TRACK; cfg_data = '0;
        cmd.valid = 1'b0; cmd.cmd_vx_mm = '0; cmd.cmd_vy_mm = '0;
        cmd.cmd_omega_mrad = '0; cmd.yaw_encoder = '0;
        wheel.ready = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Reset defaults: rpm factor zero gives zero wheels
        add_cmd(16'd1000, 16'd500, 16'd100, 13'd0);
        drain();

        // Directed: field extremes, angle wrap points, overspeed cases
        set_config(12'd400, 32'd1250000, 15'd9000);
        add_cmd(16'h7fff, 16'h7fff, 16'h7fff, 13'd0);
        add_cmd(16'h8000, 16'h8000, 16'h8000, 13'd8191);
        add_cmd(16'h7fff, 16'h8000, 16'h0000, 13'd4095);
        add_cmd(16'h8000, 16'h7fff, 16'h7fff, 13'd4096);
        add_cmd(16'd2000, 16'd0, 16'd0, 13'd2048);
        add_cmd(16'd2000, 16'd0, 16'd0, 13'd6144);
        add_cmd(16'd2000, 16'd0, 16'd0, 13'd1024);
        add_cmd(16'd2000, 16'd0, 16'd0, 13'd5120);
        add_cmd(16'd0, 16'd3000, 16'd0, 13'd7168);
        add_cmd(16'd0, 16'd0, 16'h8000, 13'd3072);
        add_cmd(16'd0, 16'd0, 16'd0, 13'd1555);
        add_cmd(-16'sd3000, 16'd0, 16'd0, 13'd2048);
        drain();

        // Zero limit and maximum factor: step bound reached
        set_config(12'd4095, 32'hffffffff, 15'd0);
        add_cmd(16'h7fff, 16'd0, 16'h7fff, 13'd2048);
        add_cmd(16'd100, 16'd100, 16'd1, 13'd10);
        add_cmd(16'h8000, 16'h8000, 16'h8000, 13'd777);
        add_cmd(16'd0, 16'd0, 16'd0, 13'd0);
        add_random(100);
        drain();

        // Random phases over a spread of settings
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: set_config(12'd0, 32'd0, 15'h7fff);
                1: set_config(12'd300, 32'd1250000, 15'd9000);
                2: set_config(12'd4095, 32'd3000000, 15'd500);
                3: set_config(12'($urandom()), $urandom(), 15'($urandom()));
                default: set_config(12'($urandom_range(0, 1000)),
                                    $urandom_range(100000, 4000000),
                                    15'($urandom_range(0, 20000)));
            endcase
            add_random(90);
            // Pause the sender until all results have come
            if (ph == 4)
            begin
                hold_sender = 1;
                while (expected_wheels.size() != 0)
                    @(posedge clk);
                @(posedge clk);
                hold_sender = 0;
            end
            add_random(90);
            drain();
        end

        $display("checked %0d wheel items from %0d commands over 11 register settings",
                 n_checked, n_sent);
        $display("%0d items were scaled, %0d hit the step bound", n_scaled, n_unsettled);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

// ===== filelist.f =====
sv/mfr_pkg.sv
sv/mfr_if.sv
sv/mfr_cordic.sv
sv/mfr_rpm.sv
sv/mfr_limit.sv
sv/mecanum_field_relative_mix_unit.sv
sv/mfr_checker.sv
verif/mfr_tb_if.sv
verif/tb.sv
